// File: rtl/time_step_error_estimator_defines.svh
// assertion macros for the time step error estimator
// no dependencies
`ifndef TIME_STEP_ERROR_ESTIMATOR_DEFINES_SVH
`define TIME_STEP_ERROR_ESTIMATOR_DEFINES_SVH
// implication checked on every edge outside reset
`define TSEE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// implication checked with the consequent in the cycle after the antecedent
`define TSEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/tsee_pkg.sv
// shared types and constants for the time step error estimator
// no dependencies
package tsee_pkg;
  localparam logic [30:0] SAT_POS = 31'h7fffffff;
  localparam logic [31:0] START_FACTOR = 32'd6553600;
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [2:0] {
    REG_TIME_STEP = 3'd0, REG_REL_TOL = 3'd1, REG_ABS_TOL = 3'd2, REG_ERR_FLOOR = 3'd3,
    REG_SAFETY = 3'd4, REG_INC_LIM = 3'd5, REG_RED_LIM = 3'd6
  } reg_idx_t;

  // classified cell handed from front to back
  typedef struct packed {
    logic [30:0] err;
    logic [30:0] tol;
    logic        last;
  } cell_t;

  typedef struct packed {
    logic [30:0] time_step;
    logic [30:0] rel_tol;
    logic [30:0] abs_tol;
    logic [30:0] err_floor;
    logic [16:0] safety;
    logic [30:0] inc_lim;
    logic [30:0] red_lim;
  } cfg_t;
endpackage

// File: rtl/time_step_error_estimator.sv
// time step error estimator: per-cell error check, running min factor and max excess
// result path: the last cell's transaction goes through queue write, back accept, bit-serial
// divide, square root, accumulate, scale and clamp; the back takes a new cell only when idle,
// while the front and the queue can take further cells during its iteration
// reset: synchronous active high; registers return to defaults, running values restart
// depends on tsee_pkg, tsee_front, tsee_queue, tsee_back and the defines header
`include "time_step_error_estimator_defines.svh"
module time_step_error_estimator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic signed [31:0] rate_now,
  input  logic signed [31:0] rate_before,
  input  logic signed [31:0] pressure,
  input  logic               last_cell,
  input  logic               in_valid,
  output logic               in_ready,
  output logic [30:0]        step_factor,
  output logic signed [31:0] max_excess,
  output logic               out_valid,
  input  logic               out_ready
);
  import tsee_pkg::*;

  cfg_t  cfg;
  cell_t f_cell;
  cell_t q_cell;
  logic  f_valid;
  logic  f_ready;
  logic  q_valid;
  logic  q_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step <= 31'd65536;
      cfg.rel_tol <= 31'd66;
      cfg.abs_tol <= 31'd66;
      cfg.err_floor <= 31'd1;
      cfg.safety <= 17'd58982;
      cfg.inc_lim <= 31'd655360;
      cfg.red_lim <= 31'd52429;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP: cfg.time_step <= cfg_data;
        REG_REL_TOL:   cfg.rel_tol <= cfg_data;
        REG_ABS_TOL:   cfg.abs_tol <= cfg_data;
        REG_ERR_FLOOR: cfg.err_floor <= cfg_data;
        REG_SAFETY:    cfg.safety <= cfg_data[16:0];
        REG_INC_LIM:   cfg.inc_lim <= cfg_data;
        REG_RED_LIM:   cfg.red_lim <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: one transaction in, error and tolerance out
  tsee_front u_front (
    .clk, .rst, .cfg, .rate_now, .rate_before, .pressure, .last_cell,
    .in_valid, .in_ready, .cdata(f_cell), .cell_valid(f_valid), .cell_ready(f_ready)
  );

  // queue lets the front take the next cell while the back iterates
  tsee_queue u_queue (
    .clk, .rst, .wr_data(f_cell), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_cell), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  // back: divide, root, accumulate, scale, final clamp
  tsee_back u_back (
    .clk, .rst, .cfg, .cdata(q_cell), .cell_valid(q_valid), .cell_ready(q_ready),
    .step_factor, .max_excess, .out_valid, .out_ready
  );

  `TSEE_ASSERT_IMP(a_floor, out_valid, step_factor >= cfg.red_lim, "factor below reduction limit")
  `TSEE_ASSERT_IMP(a_excess, out_valid, !max_excess[31], "negative max excess")
  `TSEE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(step_factor),
    "result dropped while stalled")
endmodule

// File: rtl/tsee_front.sv
// front part: forms error and tolerance of one cell in one registered stage
// depends on tsee_pkg
module tsee_front (
  input  logic                 clk,
  input  logic                 rst,
  input  tsee_pkg::cfg_t       cfg,
  input  logic signed [31:0]   rate_now,
  input  logic signed [31:0]   rate_before,
  input  logic signed [31:0]   pressure,
  input  logic                 last_cell,
  input  logic                 in_valid,
  output logic                 in_ready,
  output tsee_pkg::cell_t      cdata,
  output logic                 cell_valid,
  input  logic                 cell_ready
);
  import tsee_pkg::*;

  logic        busy;
  logic [31:0] diff;
  logic [31:0] pmag;
  logic        last;
  logic [32:0] dsum;
  logic [62:0] eprod;
  logic [62:0] tprod;
  logic [47:0] tsum;
  logic [30:0] err_c;
  logic [30:0] tol_c;

  assign dsum = {rate_now[31], rate_now} - {rate_before[31], rate_before};
  assign in_ready = !busy;
  assign cell_valid = busy;

  assign eprod = 63'(diff) * 63'(cfg.time_step);
  assign tprod = 63'(pmag) * 63'(cfg.rel_tol);
  assign tsum = 48'(tprod[62:16]) + 48'(cfg.abs_tol);
  assign err_c = (|eprod[62:48]) ? SAT_POS : eprod[47:17];
  assign tol_c = (|tsum[47:31]) ? SAT_POS : tsum[30:0];
  assign cdata = '{err: err_c, tol: tol_c, last: last};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
    end else if (cell_ready) begin
      busy <= 1'b0;
    end
    if (in_valid && in_ready) begin
      diff <= dsum[32] ? 32'(-dsum) : dsum[31:0];
      pmag <= pressure[31] ? 32'(-pressure) : pressure;
      last <= last_cell;
    end
  end
endmodule

// File: rtl/tsee_queue.sv
// short fifo between front and back
// depends on tsee_pkg
module tsee_queue (
  input  logic            clk,
  input  logic            rst,
  input  tsee_pkg::cell_t wr_data,
  input  logic            wr_valid,
  output logic            wr_ready,
  output tsee_pkg::cell_t rd_data,
  output logic            rd_valid,
  input  logic            rd_ready
);
  import tsee_pkg::*;

  cell_t      mem [QDEPTH];
  logic [0:0] wp;
  logic [0:0] rp;
  logic [1:0] count;

  assign wr_ready = count != 2'(QDEPTH);
  assign rd_valid = count != 2'd0;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr_valid && wr_ready) begin
        wp <= wp + 1'b1;
      end
      if (rd_valid && rd_ready) begin
        rp <= rp + 1'b1;
      end
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
    if (wr_valid && wr_ready) begin
      mem[wp] <= wr_data;
    end
  end
endmodule

// File: rtl/tsee_back.sv
// back part: bit-serial divide and square root, running min and max, final clamp
// depends on tsee_pkg
module tsee_back (
  input  logic            clk,
  input  logic            rst,
  input  tsee_pkg::cfg_t  cfg,
  input  tsee_pkg::cell_t cdata,
  input  logic            cell_valid,
  output logic            cell_ready,
  output logic [30:0]     step_factor,
  output logic signed [31:0] max_excess,
  output logic            out_valid,
  input  logic            out_ready
);
  import tsee_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_SQRT, S_ACC, S_SCALE, S_CLAMP, S_OUT} state_t;

  state_t      state;
  logic [5:0]  cnt;
  logic [62:0] quo;
  logic [31:0] rem;
  logic [30:0] den;
  logic [62:0] sv;
  logic [62:0] root;
  logic [62:0] sbit;
  logic [30:0] tol;
  logic [30:0] err;
  logic        last;
  logic [31:0] min_factor;
  logic signed [31:0] worst_excess;
  logic [48:0] scaled;
  logic [30:0] fac;

  logic [32:0] rem_sh;
  logic [62:0] try_v;
  logic [62:0] sq_in;
  logic [31:0] cfac;
  logic [30:0] floor_v;
  logic signed [31:0] excess;

  assign floor_v = (cfg.err_floor == '0) ? 31'd1 : cfg.err_floor;
  assign rem_sh = {rem, quo[62]};
  assign try_v = root + sbit;
  assign sq_in = (cnt == 6'd31) ? quo : sv;
  assign cfac = root[31] ? {1'b0, SAT_POS} : root[31:0];
  assign excess = $signed({1'b0, err}) - $signed({1'b0, tol});
  assign cell_ready = state == S_IDLE;
  assign out_valid = state == S_OUT;

  // scale saturation and clamps, upper first
  always_comb begin
    fac = (|scaled[48:47]) ? SAT_POS : scaled[46:16];
    if (fac > cfg.inc_lim) fac = cfg.inc_lim;
    if (fac < cfg.red_lim) fac = cfg.red_lim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      min_factor <= START_FACTOR;
      worst_excess <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cell_valid) begin
            tol <= cdata.tol;
            err <= cdata.err;
            last <= cdata.last;
            den <= (cdata.err > floor_v) ? cdata.err : floor_v;
            quo <= {cdata.tol, 32'd0};
            rem <= '0;
            cnt <= 6'd62;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle
          if (rem_sh >= 33'(den)) begin
            rem <= 32'(rem_sh - 33'(den));
            quo <= {quo[61:0], 1'b1};
          end else begin
            rem <= rem_sh[31:0];
            quo <= {quo[61:0], 1'b0};
          end
          if (cnt == 6'd0) begin
            state <= S_SQRT;
            root <= '0;
            sbit <= 63'd1 << 62;
            cnt <= 6'd31;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_SQRT: begin
          // one root bit a cycle, floor of the exact root
          if (sq_in >= try_v) begin
            sv <= sq_in - try_v;
            root <= (root >> 1) + sbit;
          end else begin
            sv <= sq_in;
            root <= root >> 1;
          end
          sbit <= sbit >> 2;
          if (cnt == 6'd0) begin
            state <= S_ACC;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_ACC: begin
          if (cfac < min_factor) min_factor <= cfac;
          if (excess > worst_excess) worst_excess <= excess;
          state <= last ? S_SCALE : S_IDLE;
        end
        S_SCALE: begin
          scaled <= 49'(min_factor) * 49'(cfg.safety);
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          step_factor <= fac;
          max_excess <= worst_excess;
          min_factor <= START_FACTOR;
          worst_excess <= '0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: test/tb_top.sv
// self-checking testbench for the time step error estimator
// holds its own cell-by-cell predictor and drives the valid/ready ports; needs tsee_pkg and the rtl
`timescale 1ns / 100ps
module tb_top;
  import tsee_pkg::*;

  localparam longint unsigned SAT_MAX = 64'h7fff_ffff;
  localparam longint unsigned FACTOR_START = 64'd6553600;
  // drain wait for the cells still in flight in front, queue and back
  localparam int DRAIN_CYCLES = 400;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [30:0]        cfg_data = '0;
  logic signed [31:0] rate_now = '0;
  logic signed [31:0] rate_before = '0;
  logic signed [31:0] pressure = '0;
  logic               last_cell = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [30:0]        step_factor;
  logic signed [31:0] max_excess;
  logic               out_valid;
  logic               out_ready = 1'b0;

  time_step_error_estimator uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .rate_now(rate_now), .rate_before(rate_before), .pressure(pressure),
    .last_cell(last_cell), .in_valid(in_valid), .in_ready(in_ready),
    .step_factor(step_factor), .max_excess(max_excess), .out_valid(out_valid),
    .out_ready(out_ready)
  );

  always #6 clk = ~clk;

  // predictor copy of the registers and running values
  longint unsigned dt_q, rtol_q, atol_q, floor_q, safety_q, inc_lim_q, red_lim_q;
  longint unsigned run_min_factor;
  longint          run_worst_excess;

  // expected step factors and excesses, oldest first
  logic [30:0]        factor_expected[$];
  logic signed [31:0] excess_expected[$];

  int fail_count = 0;
  int cells_sent = 0;
  int sweeps_checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_go = 1'b0;
  bit hold_started = 1'b0;
  int hold_left = 0;

  function automatic longint unsigned clip_pos(longint unsigned v);
    return (v > SAT_MAX) ? SAT_MAX : v;
  endfunction

  // floor of the square root, two bits at a time
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned rem;
    longint unsigned trial;
    root = 0;
    rem = 0;
    for (int i = 31; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 64'd1;
      end
    end
    return root;
  endfunction

  // accumulate one cell and queue the sweep result on the last cell
  task automatic accumulate_cell(logic signed [31:0] rn, logic signed [31:0] rb,
                                 logic signed [31:0] pr, logic lc);
    longint          delta;
    longint unsigned delta_mag, press_mag, err, tol, den, cell_factor, f;
    longint          excess;
    delta = longint'(rn) - longint'(rb);
    delta_mag = (delta < 0) ? longint'(-delta) : delta;
    err = clip_pos((delta_mag * dt_q) >> 17);
    press_mag = (pr < 0) ? longint'(-longint'(pr)) : longint'(pr);
    tol = clip_pos(((press_mag * rtol_q) >> 16) + atol_q);
    // zero floor acts as one lsb
    den = (floor_q == 0) ? 64'd1 : floor_q;
    if (err > den) den = err;
    cell_factor = clip_pos(floor_sqrt((tol << 32) / den));
    if (cell_factor < run_min_factor) run_min_factor = cell_factor;
    excess = longint'(err) - longint'(tol);
    if (excess > run_worst_excess) run_worst_excess = excess;
    if (lc) begin
      f = clip_pos((run_min_factor * safety_q) >> 16);
      // upper clamp first, lower clamp wins when the limits cross
      if (f > inc_lim_q) f = inc_lim_q;
      if (f < red_lim_q) f = red_lim_q;
      factor_expected.push_back(f[30:0]);
      excess_expected.push_back(run_worst_excess[31:0]);
      run_min_factor = FACTOR_START;
      run_worst_excess = 0;
    end
  endtask

  // one cell transaction; called and returning at a falling edge, valid left high
  task automatic send_cell(logic signed [31:0] rn, logic signed [31:0] rb,
                           logic signed [31:0] pr, logic lc);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid = 1'b1;
    rate_now = rn;
    rate_before = rb;
    pressure = pr;
    last_cell = lc;
    do @(posedge clk); while (!in_ready);
    accumulate_cell(rn, rb, pr, lc);
    cells_sent++;
    @(negedge clk);
  endtask

  task automatic wait_results_done();
    in_valid = 1'b0;
    while (factor_expected.size() != 0) @(negedge clk);
  endtask

  // registers change only with the block idle
  task automatic write_reg(reg_idx_t idx, logic [30:0] value);
    wait_results_done();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_TIME_STEP: dt_q = value;
      REG_REL_TOL:   rtol_q = value;
      REG_ABS_TOL:   atol_q = value;
      REG_ERR_FLOOR: floor_q = value;
      REG_SAFETY:    safety_q = value[16:0];
      REG_INC_LIM:   inc_lim_q = value;
      REG_RED_LIM:   red_lim_q = value;
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(200000)) - 100000;
      2: return 32'sh7fff_ffff;
      3: return 32'sh8000_0000;
      default: return $signed($urandom_range(20000000)) - 10000000;
    endcase
  endfunction

  function automatic logic [30:0] pick_reg(int unsigned hi);
    case ($urandom_range(3))
      0: return $urandom & 31'h7fff_ffff;
      1: return $urandom_range(hi);
      2: return $urandom_range(1000);
      default: return hi;
    endcase
  endfunction

  task automatic send_sweep(int len);
    for (int i = 0; i < len; i++)
      send_cell(pick_value(), pick_value(), pick_value(), i == len - 1);
  endtask

  // receiver: random stalls plus one long hold-off counted here
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_go && !hold_started) begin
      out_ready <= 1'b0;
      hold_started <= 1'b1;
      hold_left <= 1500;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (factor_expected.size() == 0) begin
        $error("result with nothing expected: step_factor %0d max_excess %0d",
               step_factor, max_excess);
        fail_count++;
      end else begin
        if (step_factor !== factor_expected[0]) begin
          $error("step_factor expected %0d actual %0d", factor_expected[0], step_factor);
          fail_count++;
        end
        if (max_excess !== excess_expected[0]) begin
          $error("max_excess expected %0d actual %0d", excess_expected[0], max_excess);
          fail_count++;
        end
        void'(factor_expected.pop_front());
        void'(excess_expected.pop_front());
        sweeps_checked++;
      end
    end
  end

  task automatic test_directed();
    // extremes of the rates and pressure in single-cell sweeps
    send_cell(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    send_cell(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
    send_cell(0, 0, 0, 1'b1);
    send_cell(32'sh0001_0000, 32'sh0000_8000, 32'sh0010_0000, 1'b1);
    send_cell(-1, 32'sh7fff_ffff, -1, 1'b1);
    // long sweep without a last cell until the end: running values keep going
    for (int i = 0; i < 6; i++)
      send_cell($signed(i * 70000) - 200000, 32'sh0000_1000, 32'sh0002_0000, i == 5);
    // zero floor treated as one lsb
    write_reg(REG_ERR_FLOOR, 31'd0);
    send_cell(5, 5, 0, 1'b1);
    send_cell(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
    // crossed limits: reduction limit wins
    write_reg(REG_INC_LIM, 31'd40000);
    write_reg(REG_RED_LIM, 31'd90000);
    send_cell(32'sh0100_0000, 0, 32'sh0001_0000, 1'b1);
    send_cell(0, 0, 32'sh7fff_ffff, 1'b1);
    // safety factor beyond one, register at its extremes
    write_reg(REG_INC_LIM, 31'h7fff_ffff);
    write_reg(REG_RED_LIM, 31'd0);
    write_reg(REG_SAFETY, 31'h1ffff);
    send_cell(0, 0, 32'sh7fff_ffff, 1'b1);
    write_reg(REG_SAFETY, 31'd0);
    send_cell(100, -100, 32'sh0001_0000, 1'b1);
    // other registers at the extremes
    write_reg(REG_TIME_STEP, 31'h7fff_ffff);
    write_reg(REG_REL_TOL, 31'h7fff_ffff);
    write_reg(REG_ABS_TOL, 31'h7fff_ffff);
    write_reg(REG_SAFETY, 31'd65536);
    write_reg(REG_ERR_FLOOR, 31'h7fff_ffff);
    send_cell(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    send_cell(32'sh8000_0000, 32'sh7fff_ffff, 0, 1'b1);
    write_reg(REG_TIME_STEP, 31'd0);
    write_reg(REG_REL_TOL, 31'd0);
    write_reg(REG_ABS_TOL, 31'd0);
    write_reg(REG_ERR_FLOOR, 31'd1);
    send_cell(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
  endtask

  task automatic test_settings();
    // a few random register sets, each with some sweeps
    for (int s = 0; s < 6; s++) begin
      write_reg(REG_TIME_STEP, pick_reg(31'd2000000));
      write_reg(REG_REL_TOL, pick_reg(31'd70000));
      write_reg(REG_ABS_TOL, pick_reg(31'd70000));
      write_reg(REG_ERR_FLOOR, pick_reg(31'd1000));
      write_reg(REG_SAFETY, $urandom_range(65536));
      write_reg(REG_INC_LIM, pick_reg(31'd1000000));
      write_reg(REG_RED_LIM, pick_reg(31'd100000));
      for (int k = 0; k < 4; k++) send_sweep($urandom_range(4, 1));
    end
  endtask

  task automatic test_backpressure();
    // receiver holds off long enough for the block to fill and stall input
    wait_results_done();
    hold_go = 1'b1;
    for (int k = 0; k < 8; k++) send_sweep(1);
    // sender pauses until every result is back
    wait_results_done();
    send_sweep(3);
  endtask

  task automatic test_random(int idle_tx, int idle_rx, int n_cells);
    int sent;
    send_idle_pct = idle_tx;
    recv_idle_pct = idle_rx;
    sent = 0;
    while (sent < n_cells) begin
      int len;
      len = $urandom_range(6, 1);
      send_sweep(len);
      sent += len;
      if ($urandom_range(19) == 0) wait_results_done();
    end
  endtask

  initial begin
    dt_q = 65536; rtol_q = 66; atol_q = 66; floor_q = 1;
    safety_q = 58982; inc_lim_q = 655360; red_lim_q = 52429;
    run_min_factor = FACTOR_START;
    run_worst_excess = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_settings();
    test_backpressure();
    write_reg(REG_TIME_STEP, 31'd65536);
    write_reg(REG_REL_TOL, 31'd66);
    write_reg(REG_ABS_TOL, 31'd66);
    write_reg(REG_ERR_FLOOR, 31'd1);
    write_reg(REG_SAFETY, 31'd58982);
    write_reg(REG_INC_LIM, 31'd655360);
    write_reg(REG_RED_LIM, 31'd52429);
    test_random(23, 57, 250);
    test_random(57, 23, 250);
    test_random(0, 0, 250);
    wait_results_done();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d cells and %0d checked sweeps over register extremes,",
             cells_sent, sweeps_checked);
    $display("crossed limits, zero floor, safety above one and output hold-off");
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("tb_top NOT OK");
    $finish;
  end
endmodule

// File: time_step_error_estimator.f
+incdir+rtl
rtl/tsee_pkg.sv
rtl/tsee_front.sv
rtl/tsee_queue.sv
rtl/tsee_back.sv
rtl/time_step_error_estimator.sv
test/tb_top.sv
